>>> src/scad_pkg.sv
// ----------------------------------------------------------------------------
// Scan code decoder package
// Types, scan code constants and the character tables shared by the decoder.
// ----------------------------------------------------------------------------
package scad_pkg;

  localparam int unsigned CodeW = 8;
  localparam int unsigned CharW = 7;

  // Scan codes that change the keyboard flags.
  localparam logic [CodeW-1:0] ScLShiftMake  = 8'h2A;
  localparam logic [CodeW-1:0] ScRShiftMake  = 8'h36;
  localparam logic [CodeW-1:0] ScLShiftBreak = 8'hAA;
  localparam logic [CodeW-1:0] ScRShiftBreak = 8'hB6;
  localparam logic [CodeW-1:0] ScCapsMake    = 8'h3A;
  localparam logic [CodeW-1:0] ScCapsBreak   = 8'hBA;

  // Control characters that both tables share.
  localparam logic [CharW-1:0] ChNone  = 7'h00;
  localparam logic [CharW-1:0] ChEnter = 7'h0A;
  localparam logic [CharW-1:0] ChSpace = 7'h20;
  localparam logic [CharW-1:0] ChBksp  = 7'h08;
  localparam logic [CharW-1:0] ChTab   = 7'h09;

  // Keyboard flags kept in the state memory.
  typedef struct packed {
    logic shift_held;
    logic caps_on;
    logic caps_released;
  } flags_t;

  localparam flags_t FlagsReset = '{shift_held: 1'b0, caps_on: 1'b0, caps_released: 1'b1};

  // Flags after one scan code.
  function automatic flags_t next_flags(input logic [CodeW-1:0] code, input flags_t cur);
    flags_t nxt;
    nxt = cur;
    if (code == ScLShiftMake || code == ScRShiftMake) begin
      nxt.shift_held = 1'b1;
    end else if (code == ScLShiftBreak || code == ScRShiftBreak) begin
      nxt.shift_held = 1'b0;
    end else if (code == ScCapsMake) begin
      if (cur.caps_released) begin
        nxt.caps_on       = ~cur.caps_on;
        nxt.caps_released = 1'b0;
      end
    end else if (code == ScCapsBreak) begin
      nxt.caps_released = 1'b1;
    end
    return nxt;
  endfunction

  // Character for a scan code; shifted selects the upper table.
  function automatic logic [CharW-1:0] lookup_char(input logic [CodeW-1:0] code,
                                                   input logic shifted);
    logic [CharW-1:0] lo;
    logic [CharW-1:0] hi;
    lo = ChNone;
    hi = ChNone;
    unique case (code)
      8'h1E: begin lo = 7'h61; hi = 7'h41; end
      8'h30: begin lo = 7'h62; hi = 7'h42; end
      8'h2E: begin lo = 7'h63; hi = 7'h43; end
      8'h20: begin lo = 7'h64; hi = 7'h44; end
      8'h12: begin lo = 7'h65; hi = 7'h45; end
      8'h21: begin lo = 7'h66; hi = 7'h46; end
      8'h22: begin lo = 7'h67; hi = 7'h47; end
      8'h23: begin lo = 7'h68; hi = 7'h48; end
      8'h17: begin lo = 7'h69; hi = 7'h49; end
      8'h24: begin lo = 7'h6A; hi = 7'h4A; end
      8'h25: begin lo = 7'h6B; hi = 7'h4B; end
      8'h26: begin lo = 7'h6C; hi = 7'h4C; end
      8'h32: begin lo = 7'h6D; hi = 7'h4D; end
      8'h31: begin lo = 7'h6E; hi = 7'h4E; end
      8'h18: begin lo = 7'h6F; hi = 7'h4F; end
      8'h19: begin lo = 7'h70; hi = 7'h50; end
      8'h10: begin lo = 7'h71; hi = 7'h51; end
      8'h13: begin lo = 7'h72; hi = 7'h52; end
      8'h1F: begin lo = 7'h73; hi = 7'h53; end
      8'h14: begin lo = 7'h74; hi = 7'h54; end
      8'h16: begin lo = 7'h75; hi = 7'h55; end
      8'h2F: begin lo = 7'h76; hi = 7'h56; end
      8'h11: begin lo = 7'h77; hi = 7'h57; end
      8'h2D: begin lo = 7'h78; hi = 7'h58; end
      8'h15: begin lo = 7'h79; hi = 7'h59; end
      8'h2C: begin lo = 7'h7A; hi = 7'h5A; end
      8'h02: begin lo = 7'h31; hi = 7'h21; end
      8'h03: begin lo = 7'h32; hi = 7'h40; end
      8'h04: begin lo = 7'h33; hi = 7'h23; end
      8'h05: begin lo = 7'h34; hi = 7'h24; end
      8'h06: begin lo = 7'h35; hi = 7'h25; end
      8'h07: begin lo = 7'h36; hi = 7'h5E; end
      8'h08: begin lo = 7'h37; hi = 7'h26; end
      8'h09: begin lo = 7'h38; hi = 7'h2A; end
      8'h0A: begin lo = 7'h39; hi = 7'h28; end
      8'h0B: begin lo = 7'h30; hi = 7'h29; end
      8'h0C: begin lo = 7'h2D; hi = 7'h5F; end
      8'h0D: begin lo = 7'h3D; hi = 7'h2B; end
      8'h2B: begin lo = 7'h5C; hi = 7'h7C; end
      8'h1A: begin lo = 7'h5B; hi = 7'h7B; end
      8'h1B: begin lo = 7'h5D; hi = 7'h7D; end
      8'h27: begin lo = 7'h3B; hi = 7'h3A; end
      8'h28: begin lo = 7'h27; hi = 7'h22; end
      8'h33: begin lo = 7'h2C; hi = 7'h3C; end
      8'h34: begin lo = 7'h2E; hi = 7'h3E; end
      8'h35: begin lo = 7'h2F; hi = 7'h3F; end
      8'h9C: begin lo = ChEnter; hi = ChEnter; end
      8'h39: begin lo = ChSpace; hi = ChSpace; end
      8'h0E: begin lo = ChBksp;  hi = ChBksp;  end
      8'h0F: begin lo = ChTab;   hi = ChTab;   end
      default: begin lo = ChNone; hi = ChNone; end
    endcase
    return shifted ? hi : lo;
  endfunction

endpackage

>>> src/scancode_to_ascii_decoder.sv
// ----------------------------------------------------------------------------
// Scan code to ASCII decoder
// Stage 1 registers an accepted request and its flag read; the output register then takes its character.
// Throughput: one request per cycle unless stalled, set by the single read-modify-write
// of the flag memory per request; a stalled output holds one result and one request.
// Reset: rst_ni clears all valid flags; the flags read as shift released,
// caps lock off and caps key released until the first request writes them.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] scan_code
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [6:0] ascii_char, [7] zero
);

  // Stage 1 holds the request whose flags come back from the memory.
  logic                       s1_valid_q, s1_valid_d;
  logic [scad_pkg::CodeW-1:0] s1_code_q;
  logic                       s1_adv;
  logic                       in_acc;

  // Output register; it decouples the decode from a stalled consumer.
  logic                       out_valid_q, out_valid_d;
  logic [scad_pkg::CharW-1:0] out_char_q;

  // Forwarding: the memory read issued in the same cycle as a write returns
  // stale flags, so the written value is kept and selected instead.
  logic                       fwd_sel_q;
  scad_pkg::flags_t           fwd_flags_q;

  scad_pkg::flags_t           rd_flags;
  scad_pkg::flags_t           cur_flags;
  scad_pkg::flags_t           new_flags;
  logic [scad_pkg::CharW-1:0] dec_char;

  // Stage 1 moves on whenever the output register is free or being emptied.
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !m_axis_tready_i);

  scad_flag_mem u_flag_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .wr_en_i   (s1_adv),
    .wr_data_i (new_flags),
    .rd_data_o (rd_flags)
  );

  assign cur_flags = fwd_sel_q ? fwd_flags_q : rd_flags;

  scad_decode u_decode (
    .code_i  (s1_code_q),
    .flags_i (cur_flags),
    .flags_o (new_flags),
    .char_o  (dec_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_sel_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // The selection is fixed when a request enters and held while it waits.
      // It drops once stage 1 empties.
      if (in_acc) begin
        fwd_sel_q <= s1_adv;
      end else if (s1_adv) begin
        fwd_sel_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_code_q <= s_axis_tdata_i;
    end
    if (s1_adv) begin
      fwd_flags_q <= new_flags;
      out_char_q  <= dec_char;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};

  // Forwarded flags are only ever selected for a request that is waiting in stage 1.
  a_fwd_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_sel_q |-> s1_valid_q)
    else $error("forward select set with stage 1 empty");

  // A new result appears only after stage 1 handed one over.
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv))
    else $error("output became valid without a stage 1 transfer");

  // The input stalls only when both stages are full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (s1_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a full pipeline");

  // A request in stage 1 that cannot move keeps its scan code.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_code_q)))
    else $error("stalled stage 1 request changed");

endmodule

>>> src/scad_flag_mem.sv
// ----------------------------------------------------------------------------
// Keyboard flag memory
// Single-entry synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module scad_flag_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic              wr_en_i,
  input  scad_pkg::flags_t  wr_data_i,
  output scad_pkg::flags_t  rd_data_o
);

  scad_pkg::flags_t mem_q [1];
  scad_pkg::flags_t rd_data_q;
  logic             written_q;

  // The entry reads as the reset flags until its first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= 1'b0;
    end else if (wr_en_i) begin
      written_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[0] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= written_q ? mem_q[0] : scad_pkg::FlagsReset;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/scad_decode.sv
// ----------------------------------------------------------------------------
// Scan code decode
// Updates the keyboard flags and looks up the character with the new flags.
// ----------------------------------------------------------------------------
module scad_decode (
  input  logic [scad_pkg::CodeW-1:0] code_i,
  input  scad_pkg::flags_t           flags_i,
  output scad_pkg::flags_t           flags_o,
  output logic [scad_pkg::CharW-1:0] char_o
);

  scad_pkg::flags_t flags_nxt;

  always_comb begin
    flags_nxt = scad_pkg::next_flags(code_i, flags_i);
    char_o    = scad_pkg::lookup_char(code_i, flags_nxt.shift_held ^ flags_nxt.caps_on);
  end

  assign flags_o = flags_nxt;

endmodule
